// ----- design/utcn_pkg.sv -----
// utcn_pkg: shared constants and tables for the utc time normalizer
`timescale 1ns / 1ps

package utcn_pkg;

  // pipeline depth, input to output register
  localparam int NSTG = 14;

  // month fold: u = month + 12*171, 13 bits
  localparam int     MON_N    = 13;
  localparam int     MON_D    = 12;
  localparam int     MON_S    = MON_N + $clog2(MON_D);
  localparam longint MON_M    = ((longint'(1) << MON_S) + MON_D - 1) / MON_D;
  localparam int     MON_MW   = $clog2(MON_M + 1);
  localparam int     MON_QW   = 9;
  localparam int     MON_BIAS = 2052;
  localparam int     MON_OFS  = 171;

  // divide by 60, shared by the second and minute folds (17 bit operand)
  localparam int     D60_N  = 17;
  localparam int     D60_D  = 60;
  localparam int     D60_S  = D60_N + $clog2(D60_D);
  localparam longint D60_M  = ((longint'(1) << D60_S) + D60_D - 1) / D60_D;
  localparam int     D60_MW = $clog2(D60_M + 1);
  localparam int     D60_QW = 11;
  localparam int     SEC_BIAS = 32820;
  localparam int     SEC_OFS  = 547;
  localparam int     MIN_BIAS = 33360;
  localparam int     MIN_OFS  = 556;

  // hour fold
  localparam int     HR_N  = 17;
  localparam int     HR_D  = 24;
  localparam int     HR_S  = HR_N + $clog2(HR_D);
  localparam longint HR_M  = ((longint'(1) << HR_S) + HR_D - 1) / HR_D;
  localparam int     HR_MW = $clog2(HR_M + 1);
  localparam int     HR_QW = 12;
  localparam int     HR_BIAS = 33336;
  localparam int     HR_OFS  = 1389;

  // century count of the biased march-based year
  localparam int     YR_N  = 15;
  localparam int     YR_D  = 100;
  localparam int     YR_S  = YR_N + $clog2(YR_D);
  localparam longint YR_M  = ((longint'(1) << YR_S) + YR_D - 1) / YR_D;
  localparam int     YR_MW = $clog2(YR_M + 1);
  localparam int     YR_QW = 8;
  localparam int     YR_BIAS = 6800;
  // epoch offset of the biased day count
  localparam int     DAYS_C  = 3203117;

  // era split of the biased day number
  localparam int     ERA_N  = 23;
  localparam int     ERA_D  = 146097;
  localparam int     ERA_S  = ERA_N + $clog2(ERA_D);
  localparam longint ERA_M  = ((longint'(1) << ERA_S) + ERA_D - 1) / ERA_D;
  localparam int     ERA_MW = $clog2(ERA_M + 1);
  localparam int     ERA_QW = 6;
  localparam int     ERA_OFS = 17;
  localparam int     Z_BIAS  = 3203117;

  // day of era corrections
  localparam int     DA_N  = 18;
  localparam int     DA_D  = 1460;
  localparam int     DA_S  = DA_N + $clog2(DA_D);
  localparam longint DA_M  = ((longint'(1) << DA_S) + DA_D - 1) / DA_D;
  localparam int     DA_MW = $clog2(DA_M + 1);
  localparam int     DA_QW = 7;

  localparam int     DB_N  = 18;
  localparam int     DB_D  = 36524;
  localparam int     DB_S  = DB_N + $clog2(DB_D);
  localparam longint DB_M  = ((longint'(1) << DB_S) + DB_D - 1) / DB_D;
  localparam int     DB_MW = $clog2(DB_M + 1);
  localparam int     DB_QW = 3;

  localparam int     DC_N  = 18;
  localparam int     DC_D  = 146096;
  localparam int     DC_S  = DC_N + $clog2(DC_D);
  localparam longint DC_M  = ((longint'(1) << DC_S) + DC_D - 1) / DC_D;
  localparam int     DC_MW = $clog2(DC_M + 1);
  localparam int     DC_QW = 1;

  // year of era
  localparam int     YOE_N  = 18;
  localparam int     YOE_D  = 365;
  localparam int     YOE_S  = YOE_N + $clog2(YOE_D);
  localparam longint YOE_M  = ((longint'(1) << YOE_S) + YOE_D - 1) / YOE_D;
  localparam int     YOE_MW = $clog2(YOE_M + 1);
  localparam int     YOE_QW = 9;

  // march-based month from day of year
  localparam int     MP_N  = 11;
  localparam int     MP_D  = 153;
  localparam int     MP_S  = MP_N + $clog2(MP_D);
  localparam longint MP_M  = ((longint'(1) << MP_S) + MP_D - 1) / MP_D;
  localparam int     MP_MW = $clog2(MP_M + 1);
  localparam int     MP_QW = 4;

  // weekday, day of era plus three, mod 7
  localparam int     WD_N  = 18;
  localparam int     WD_D  = 7;
  localparam int     WD_S  = WD_N + $clog2(WD_D);
  localparam longint WD_M  = ((longint'(1) << WD_S) + WD_D - 1) / WD_D;
  localparam int     WD_MW = $clog2(WD_M + 1);
  localparam int     WD_QW = 15;

  // first day of each march-based month, counted from march 1
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/utc_broken_down_time_normalizer.sv -----
// utc_broken_down_time_normalizer: pipelined broken-down time to epoch seconds
`timescale 1ns / 1ps

// Converts one broken-down UTC time per clock, while out_ready holds, into epoch
// seconds and canonical calendar fields (proleptic Gregorian, no time zone). The
// datapath is a 14-stage pipeline with registered out_ ports, and a new item can
// enter every cycle unless the pipeline is full and stalled. Every division by a
// calendar constant is a reciprocal multiply, and the chain of dependent multiplies
// sets the depth. Each stage holds its item while the next one is full and stalled;
// in_ready drops only when every stage is full and out_ready is low.
module utc_broken_down_time_normalizer
  import utcn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [13:0] in_year_since_1900,
  input  logic signed [11:0] in_month_raw,
  input  logic signed [15:0] in_day_raw,
  input  logic signed [15:0] in_hour_raw,
  input  logic signed [15:0] in_minute_raw,
  input  logic signed [15:0] in_second_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [38:0] out_epoch_seconds,
  output logic [5:0]         out_norm_second,
  output logic [5:0]         out_norm_minute,
  output logic [4:0]         out_norm_hour,
  output logic [4:0]         out_norm_day,
  output logic [3:0]         out_norm_month,
  output logic signed [14:0] out_norm_year_since_1900,
  output logic [2:0]         out_weekday,
  output logic [8:0]         out_year_day
);

  logic [NSTG:1] v_r;
  logic [NSTG:1] rdy;
  logic [NSTG:1] vin;

  // stall chain: a stage loads when empty or when the next one moves
  always_comb begin
    rdy[NSTG] = !v_r[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    vin = {v_r[NSTG-1:1], in_valid};
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) v_r[k] <= vin[k];
      end
    end
  end

  // stage 1: bias month and second, reciprocal multiply
  logic [MON_N-1:0]            umon_nxt;
  logic [MON_N+MON_MW-1:0]     pmon;
  logic [D60_N-1:0]            usec_nxt;
  logic [D60_N+D60_MW-1:0]     psec;
  logic signed [13:0]          ys1_r;
  logic [MON_N-1:0]            umon1_r;
  logic [MON_QW-1:0]           qmon1_r;
  logic [D60_N-1:0]            usec1_r;
  logic [D60_QW-1:0]           qsec1_r;
  logic signed [15:0]          day1_r, hr1_r, mi1_r;

  always_comb begin
    umon_nxt = MON_N'(14'(in_month_raw) + 14'(MON_BIAS));
    pmon     = (MON_N+MON_MW)'(umon_nxt) * (MON_N+MON_MW)'(MON_M);
    usec_nxt = D60_N'(18'(in_second_raw) + 18'(SEC_BIAS));
    psec     = (D60_N+D60_MW)'(usec_nxt) * (D60_N+D60_MW)'(D60_M);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ys1_r   <= in_year_since_1900;
      umon1_r <= umon_nxt;
      qmon1_r <= pmon[MON_S +: MON_QW];
      usec1_r <= usec_nxt;
      qsec1_r <= psec[D60_S +: D60_QW];
      day1_r  <= in_day_raw;
      hr1_r   <= in_hour_raw;
      mi1_r   <= in_minute_raw;
    end
  end

  // stage 2: month and second remainders, year carry, biased minute
  logic signed [14:0] y2_r;
  logic [3:0]         mon2_r;
  logic [5:0]         rs2_r;
  logic [D60_N-1:0]   umin2_r;
  logic signed [15:0] day2_r, hr2_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      mon2_r  <= 4'(umon1_r - MON_N'(qmon1_r) * MON_N'(MON_D));
      y2_r    <= 15'(ys1_r) + 15'(qmon1_r) + 15'(1900 - MON_OFS);
      rs2_r   <= 6'(usec1_r - D60_N'(qsec1_r) * D60_N'(D60_D));
      umin2_r <= D60_N'(18'(mi1_r) + 18'(qsec1_r) + 18'(MIN_BIAS - SEC_OFS));
      day2_r  <= day1_r;
      hr2_r   <= hr1_r;
    end
  end

  // stage 3: minute divide, march-based year and month
  logic [D60_N+D60_MW-1:0] pmin;
  logic                    jf2;
  logic [YR_N-1:0]         uyr3_r;
  logic [3:0]              mp3_r;
  logic [5:0]              rs3_r;
  logic [D60_N-1:0]        umin3_r;
  logic [D60_QW-1:0]       qmin3_r;
  logic signed [15:0]      day3_r, hr3_r;

  always_comb begin
    pmin = (D60_N+D60_MW)'(umin2_r) * (D60_N+D60_MW)'(D60_M);
    jf2  = (mon2_r < 4'd2);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      uyr3_r  <= YR_N'(16'(y2_r) - 16'(jf2) + 16'(YR_BIAS));
      mp3_r   <= jf2 ? 4'(mon2_r + 4'd10) : 4'(mon2_r - 4'd2);
      rs3_r   <= rs2_r;
      umin3_r <= umin2_r;
      qmin3_r <= pmin[D60_S +: D60_QW];
      day3_r  <= day2_r;
      hr3_r   <= hr2_r;
    end
  end

  // stage 4: minute remainder, biased hour, century count
  logic [YR_N+YR_MW-1:0] pyr;
  logic [YR_N-1:0]       uyr4_r;
  logic [YR_QW-1:0]      q100_4_r;
  logic [3:0]            mp4_r;
  logic signed [15:0]    day4_r;
  logic [5:0]            rs4_r, rm4_r;
  logic [HR_N-1:0]       uhr4_r;

  assign pyr = (YR_N+YR_MW)'(uyr3_r) * (YR_N+YR_MW)'(YR_M);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      uyr4_r   <= uyr3_r;
      q100_4_r <= pyr[YR_S +: YR_QW];
      mp4_r    <= mp3_r;
      day4_r   <= day3_r;
      rs4_r    <= rs3_r;
      rm4_r    <= 6'(umin3_r - D60_N'(qmin3_r) * D60_N'(D60_D));
      uhr4_r   <= HR_N'(18'(hr3_r) + 18'(qmin3_r) + 18'(HR_BIAS - MIN_OFS));
    end
  end

  // stage 5: hour divide, day count of the folded date
  logic [HR_N+HR_MW-1:0] phr;
  logic [24:0]           days_nxt;
  logic signed [23:0]    days5_r;
  logic [HR_QW-1:0]      qhr5_r;
  logic [HR_N-1:0]       uhr5_r;
  logic [5:0]            rs5_r, rm5_r;

  always_comb begin
    phr      = (HR_N+HR_MW)'(uhr4_r) * (HR_N+HR_MW)'(HR_M);
    days_nxt = 25'(uyr4_r) * 25'(365) + 25'(uyr4_r >> 2) - 25'(q100_4_r)
             + 25'(q100_4_r >> 2) + 25'(month_start(mp4_r)) + 25'(day4_r)
             - 25'(1) - 25'(DAYS_C);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      days5_r <= 24'(days_nxt);
      qhr5_r  <= phr[HR_S +: HR_QW];
      uhr5_r  <= uhr4_r;
      rs5_r   <= rs4_r;
      rm5_r   <= rm4_r;
    end
  end

  // stage 6: hour remainder, whole day number and its biased form
  logic signed [23:0] nd_nxt;
  logic signed [23:0] nd6_r;
  logic [ERA_N-1:0]   v6_r;
  logic [5:0]         rs6_r, rm6_r;
  logic [4:0]         rh6_r;

  assign nd_nxt = days5_r + 24'(qhr5_r) - 24'(HR_OFS);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      nd6_r <= nd_nxt;
      v6_r  <= ERA_N'(nd_nxt + 24'(Z_BIAS));
      rs6_r <= rs5_r;
      rm6_r <= rm5_r;
      rh6_r <= 5'(uhr5_r - HR_N'(qhr5_r) * HR_N'(HR_D));
    end
  end

  // stage 7: era divide, day part of the epoch seconds
  logic [ERA_N+ERA_MW-1:0] pera;
  logic [ERA_N-1:0]        v7_r;
  logic [ERA_QW-1:0]       era7_r;
  logic signed [40:0]      tp7_r;
  logic [5:0]              rs7_r, rm7_r;
  logic [4:0]              rh7_r;

  assign pera = (ERA_N+ERA_MW)'(v6_r) * (ERA_N+ERA_MW)'(ERA_M);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      v7_r   <= v6_r;
      era7_r <= pera[ERA_S +: ERA_QW];
      tp7_r  <= 41'(nd6_r) * 41'(86400);
      rs7_r  <= rs6_r;
      rm7_r  <= rm6_r;
      rh7_r  <= rh6_r;
    end
  end

  // stage 8: day of era, epoch seconds
  logic [DA_N-1:0]    doe8_r;
  logic [ERA_QW-1:0]  era8_r;
  logic signed [38:0] t8_r;
  logic [5:0]         rs8_r, rm8_r;
  logic [4:0]         rh8_r;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      doe8_r <= DA_N'(v7_r - ERA_N'(era7_r) * ERA_N'(ERA_D));
      era8_r <= era7_r;
      t8_r   <= 39'(tp7_r + 41'(rh7_r) * 41'(3600) + 41'(rm7_r) * 41'(60) + 41'(rs7_r));
      rs8_r  <= rs7_r;
      rm8_r  <= rm7_r;
      rh8_r  <= rh7_r;
    end
  end

  // stage 9: leap corrections and weekday divide
  logic [DA_N+DA_MW-1:0] pa;
  logic [DB_N+DB_MW-1:0] pb;
  logic [DC_N+DC_MW-1:0] pc;
  logic [WD_N+WD_MW-1:0] pw;
  logic [DA_N-1:0]       doe8p3;
  logic [DA_N-1:0]       doe9_r;
  logic [DA_QW-1:0]      a9_r;
  logic [DB_QW-1:0]      b9_r;
  logic [DC_QW-1:0]      c9_r;
  logic [WD_QW-1:0]      w9_r;
  logic [ERA_QW-1:0]     era9_r;
  logic signed [38:0]    t9_r;
  logic [5:0]            rs9_r, rm9_r;
  logic [4:0]            rh9_r;

  always_comb begin
    doe8p3 = doe8_r + DA_N'(3);
    pa = (DA_N+DA_MW)'(doe8_r) * (DA_N+DA_MW)'(DA_M);
    pb = (DB_N+DB_MW)'(doe8_r) * (DB_N+DB_MW)'(DB_M);
    pc = (DC_N+DC_MW)'(doe8_r) * (DC_N+DC_MW)'(DC_M);
    pw = (WD_N+WD_MW)'(doe8p3) * (WD_N+WD_MW)'(WD_M);
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      doe9_r <= doe8_r;
      a9_r   <= pa[DA_S +: DA_QW];
      b9_r   <= pb[DB_S +: DB_QW];
      c9_r   <= pc[DC_S +: DC_QW];
      w9_r   <= pw[WD_S +: WD_QW];
      era9_r <= era8_r;
      t9_r   <= t8_r;
      rs9_r  <= rs8_r;
      rm9_r  <= rm8_r;
      rh9_r  <= rh8_r;
    end
  end

  // stage 10: year of era numerator, weekday remainder
  logic [DA_N-1:0]    doe10_r;
  logic [YOE_N-1:0]   num10_r;
  logic [2:0]         wd10_r;
  logic [ERA_QW-1:0]  era10_r;
  logic signed [38:0] t10_r;
  logic [5:0]         rs10_r, rm10_r;
  logic [4:0]         rh10_r;

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      doe10_r <= doe9_r;
      num10_r <= YOE_N'(doe9_r - DA_N'(a9_r) + DA_N'(b9_r) - DA_N'(c9_r));
      wd10_r  <= 3'(doe9_r + DA_N'(3) - DA_N'(w9_r) * DA_N'(WD_D));
      era10_r <= era9_r;
      t10_r   <= t9_r;
      rs10_r  <= rs9_r;
      rm10_r  <= rm9_r;
      rh10_r  <= rh9_r;
    end
  end

  // stage 11: year of era divide
  logic [YOE_N+YOE_MW-1:0] pyoe;
  logic [DA_N-1:0]         doe11_r;
  logic [YOE_QW-1:0]       yoe11_r;
  logic [2:0]              wd11_r;
  logic [ERA_QW-1:0]       era11_r;
  logic signed [38:0]      t11_r;
  logic [5:0]              rs11_r, rm11_r;
  logic [4:0]              rh11_r;

  assign pyoe = (YOE_N+YOE_MW)'(num10_r) * (YOE_N+YOE_MW)'(YOE_M);

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      doe11_r <= doe10_r;
      yoe11_r <= pyoe[YOE_S +: YOE_QW];
      wd11_r  <= wd10_r;
      era11_r <= era10_r;
      t11_r   <= t10_r;
      rs11_r  <= rs10_r;
      rm11_r  <= rm10_r;
      rh11_r  <= rh10_r;
    end
  end

  // stage 12: day of march-based year
  logic [1:0]         cent;
  logic [DA_N-1:0]    ystart;
  logic [8:0]         doy12_r;
  logic [YOE_QW-1:0]  yoe12_r;
  logic [2:0]         wd12_r;
  logic [ERA_QW-1:0]  era12_r;
  logic signed [38:0] t12_r;
  logic [5:0]         rs12_r, rm12_r;
  logic [4:0]         rh12_r;

  always_comb begin
    if (yoe11_r >= YOE_QW'(300))      cent = 2'd3;
    else if (yoe11_r >= YOE_QW'(200)) cent = 2'd2;
    else if (yoe11_r >= YOE_QW'(100)) cent = 2'd1;
    else                              cent = 2'd0;
    ystart = DA_N'(yoe11_r) * DA_N'(365) + DA_N'(yoe11_r >> 2) - DA_N'(cent);
  end

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      doy12_r <= 9'(doe11_r - ystart);
      yoe12_r <= yoe11_r;
      wd12_r  <= wd11_r;
      era12_r <= era11_r;
      t12_r   <= t11_r;
      rs12_r  <= rs11_r;
      rm12_r  <= rm11_r;
      rh12_r  <= rh11_r;
    end
  end

  // stage 13: march-based month divide, leap flag
  logic [MP_N-1:0]       mpn;
  logic [MP_N+MP_MW-1:0] pmp;
  logic [8:0]            doy13_r;
  logic [MP_QW-1:0]      mp13_r;
  logic                  leap13_r;
  logic [YOE_QW-1:0]     yoe13_r;
  logic [2:0]            wd13_r;
  logic [ERA_QW-1:0]     era13_r;
  logic signed [38:0]    t13_r;
  logic [5:0]            rs13_r, rm13_r;
  logic [4:0]            rh13_r;

  always_comb begin
    mpn = MP_N'(doy12_r) * MP_N'(5) + MP_N'(2);
    pmp = (MP_N+MP_MW)'(mpn) * (MP_N+MP_MW)'(MP_M);
  end

  always_ff @(posedge clk) begin
    if (rdy[13]) begin
      doy13_r  <= doy12_r;
      mp13_r   <= pmp[MP_S +: MP_QW];
      // march-based year is leap: multiple of 4, not a non-400 century
      leap13_r <= (yoe12_r[1:0] == 2'd0) && !(yoe12_r == YOE_QW'(100)
                  || yoe12_r == YOE_QW'(200) || yoe12_r == YOE_QW'(300));
      yoe13_r  <= yoe12_r;
      wd13_r   <= wd12_r;
      era13_r  <= era12_r;
      t13_r    <= t12_r;
      rs13_r   <= rs12_r;
      rm13_r   <= rm12_r;
      rh13_r   <= rh12_r;
    end
  end

  // stage 14: calendar fields, output register
  logic               jan_feb;
  logic [15:0]        oy_nxt;
  logic [9:0]         od_nxt;

  always_comb begin
    jan_feb = (mp13_r >= MP_QW'(10));
    od_nxt  = 10'(doy13_r) - 10'(month_start(mp13_r)) + 10'(1);
    oy_nxt  = 16'(yoe13_r) + (16'(era13_r) - 16'(ERA_OFS)) * 16'(400)
            + 16'(jan_feb) - 16'(1900);
  end

  always_ff @(posedge clk) begin
    if (rdy[14]) begin
      out_epoch_seconds        <= t13_r;
      out_norm_second          <= rs13_r;
      out_norm_minute          <= rm13_r;
      out_norm_hour            <= rh13_r;
      out_norm_day             <= 5'(od_nxt);
      out_norm_month           <= jan_feb ? 4'(mp13_r - MP_QW'(10)) : 4'(mp13_r + MP_QW'(2));
      out_norm_year_since_1900 <= 15'(oy_nxt);
      out_weekday              <= wd13_r;
      out_year_day             <= jan_feb ? 9'(doy13_r - 9'd306)
                                          : 9'(doy13_r + 9'd59 + 9'(leap13_r));
    end
  end

endmodule

// ----- design/utcn_checker.sv -----
// utcn_checker: port-level assertions for the utc time normalizer
`timescale 1ns / 1ps

module utcn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [38:0] out_epoch_seconds,
  input logic [5:0]         out_norm_second,
  input logic [5:0]         out_norm_minute,
  input logic [4:0]         out_norm_hour,
  input logic [4:0]         out_norm_day,
  input logic [3:0]         out_norm_month,
  input logic [2:0]         out_weekday,
  input logic [8:0]         out_year_day
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_epoch_seconds))
    else $error("stalled result item changed or dropped");

  // an empty output stage never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // time of day fields are canonical
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_second < 6'd60 && out_norm_minute < 6'd60
                  && out_norm_hour < 5'd24)
    else $error("time of day out of range");

  // calendar fields are canonical
  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_month < 4'd12 && out_norm_day != 5'd0
                  && out_weekday < 3'd7 && out_year_day <= 9'd365)
    else $error("calendar field out of range");

endmodule

bind utc_broken_down_time_normalizer utcn_checker u_utcn_checker (.*);
